@@ hw/rtl/lsbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED strand bit-plane packer: shared types and constants
// Payload structs, command codes, queue entry format and state encodings.
// ----------------------------------------------------------------------------
package lsbp_pkg;

    localparam logic [7:0] CMD_BEGIN  = 8'h42;
    localparam logic [7:0] CMD_END    = 8'h45;
    localparam logic [7:0] CMD_STRAND = 8'h53;
    localparam logic [7:0] FRAME_MARK = 8'h2A;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;

    localparam int PARSE_W = 17;
    localparam logic [PARSE_W-1:0] PARSE_MAX = '1;

    localparam int STRAND_FW    = 6;
    localparam int ADDR_FW      = 16;
    localparam int LENGTH_FW    = 16;
    localparam int STRAND_SUM_W = 7;
    localparam int QUEUE_DEPTH  = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_STRAND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_STRAND  = 1'b1;

    typedef enum logic [2:0] {
        OP_BEGIN,
        OP_END,
        OP_WRITE,
        OP_SETLEN,
        OP_PULL
    } op_kind_t;

    typedef enum logic [1:0] {
        PH_0,
        PH_1,
        PH_2
    } triple_phase_t;

    typedef enum logic {
        BK_IDLE,
        BK_GATHER
    } back_state_t;

    typedef struct packed {
        logic       action;
        logic [7:0] packet_byte;
        logic       packet_first;
    } in_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       out_last;
    } out_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [STRAND_FW-1:0]   strand;
        logic [ADDR_FW-1:0]     addr;
        logic [LENGTH_FW-1:0]   length;
        logic [7:0]             data;
    } op_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage
`default_nettype wire

@@ hw/rtl/lsbp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED strand bit-plane packer: packet parser
// Accepts input items, tracks packet framing and turns each item into at most
// one operation for the execution side.
// ----------------------------------------------------------------------------
module lsbp_front #(
    parameter int MAX_STRAND_COUNT = 16,
    parameter int STRAND_BYTES     = 2048
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    output logic            s_ready,
    input  lsbp_pkg::in_t   s_payload,
    input  wire             q_full,
    output logic            q_push,
    output lsbp_pkg::op_t   q_entry
);
    import lsbp_pkg::*;

    localparam logic [PARSE_W-1:0] IDX_STRAND  = PARSE_W'(1);
    localparam logic [PARSE_W-1:0] IDX_LEN_LO  = PARSE_W'(2);
    localparam logic [PARSE_W-1:0] IDX_LEN_HI  = PARSE_W'(3);
    localparam logic [PARSE_W-1:0] IDX_PAYLOAD = PARSE_W'(4);
    localparam logic [PARSE_W-1:0] SB_LIMIT    = PARSE_W'(STRAND_BYTES);
    localparam logic [7:0]         STRAND_LIM  = 8'(MAX_STRAND_COUNT - 1);

    logic [PARSE_W-1:0]   parse_idx_reg, parse_idx_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic [7:0]           strand_reg, strand_next;
    logic [15:0]          len_reg, len_next;
    triple_phase_t        phase_reg, phase_next;

    logic                 accept;
    logic                 strand_ok;
    logic [PARSE_W-1:0]   offset;
    logic [PARSE_W-1:0]   plen_ext;
    logic [PARSE_W-1:0]   wr_addr;
    logic                 wr_ok;
    logic [15:0]          len_full;
    logic [15:0]          len_sat;

    assign s_ready   = !q_full;
    assign accept    = s_valid && !q_full;
    assign strand_ok = strand_reg < STRAND_LIM;
    assign offset    = parse_idx_reg - IDX_PAYLOAD;
    assign plen_ext  = PARSE_W'(len_reg);
    assign len_full  = {s_payload.packet_byte, len_reg[7:0]};
    assign len_sat   = (PARSE_W'(len_full) < SB_LIMIT) ? len_full : 16'(STRAND_BYTES);

    // The first two bytes of each triple trade places when both are present.
    always_comb begin
        wr_addr = offset;
        unique case (phase_reg)
            PH_0: begin
                if (offset + PARSE_W'(1) < plen_ext) begin
                    wr_addr = offset + PARSE_W'(1);
                end
            end
            PH_1: begin
                wr_addr = offset - PARSE_W'(1);
            end
            default: begin
                wr_addr = offset;
            end
        endcase
    end

    assign wr_ok = strand_ok && (offset < plen_ext) && (offset < SB_LIMIT)
                   && (wr_addr < SB_LIMIT);

    always_comb begin
        parse_idx_next = parse_idx_reg;
        cmd_next       = cmd_reg;
        strand_next    = strand_reg;
        len_next       = len_reg;
        phase_next     = phase_reg;
        q_push         = 1'b0;
        q_entry.kind   = OP_PULL;
        q_entry.strand = strand_reg[STRAND_FW-1:0];
        q_entry.addr   = wr_addr[ADDR_FW-1:0];
        q_entry.length = len_sat;
        q_entry.data   = s_payload.packet_byte;
        if (accept) begin
            if (s_payload.action) begin
                q_push       = 1'b1;
                q_entry.kind = OP_PULL;
            end else if (s_payload.packet_first) begin
                parse_idx_next = IDX_STRAND;
                cmd_next       = s_payload.packet_byte;
                phase_next     = PH_0;
                if (s_payload.packet_byte == CMD_BEGIN) begin
                    q_push       = 1'b1;
                    q_entry.kind = OP_BEGIN;
                end else if (s_payload.packet_byte == CMD_END) begin
                    q_push       = 1'b1;
                    q_entry.kind = OP_END;
                end
            end else begin
                if (cmd_reg == CMD_STRAND) begin
                    if (parse_idx_reg == IDX_STRAND) begin
                        strand_next = s_payload.packet_byte;
                    end else if (parse_idx_reg == IDX_LEN_LO) begin
                        len_next = {len_reg[15:8], s_payload.packet_byte};
                    end else if (parse_idx_reg == IDX_LEN_HI) begin
                        len_next = len_full;
                        if (strand_ok) begin
                            q_push       = 1'b1;
                            q_entry.kind = OP_SETLEN;
                        end
                    end else if (parse_idx_reg >= IDX_PAYLOAD) begin
                        if (wr_ok) begin
                            q_push       = 1'b1;
                            q_entry.kind = OP_WRITE;
                        end
                        unique case (phase_reg)
                            PH_0:    phase_next = PH_1;
                            PH_1:    phase_next = PH_2;
                            default: phase_next = PH_0;
                        endcase
                    end
                end
                if (parse_idx_reg != PARSE_MAX) begin
                    parse_idx_next = parse_idx_reg + PARSE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_idx_reg <= '0;
            cmd_reg       <= '0;
            strand_reg    <= '0;
            len_reg       <= '0;
            phase_reg     <= PH_0;
        end else begin
            parse_idx_reg <= parse_idx_next;
            cmd_reg       <= cmd_next;
            strand_reg    <= strand_next;
            len_reg       <= len_next;
            phase_reg     <= phase_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lsbp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED strand bit-plane packer: operation queue
// Short first-in first-out buffer between the parser and the execution side.
// ----------------------------------------------------------------------------
module lsbp_fifo (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  lsbp_pkg::op_t   push_entry,
    output logic            full,
    input  wire             pop,
    output logic            head_valid,
    output lsbp_pkg::op_t   head
);
    import lsbp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full       = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lsbp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED strand bit-plane packer: execution side
// Holds the banked strand stores and lengths, writes payload bytes, forwards begin
// and end events, and gathers one bit-plane byte from up to eight strand banks per transfer.
// ----------------------------------------------------------------------------
module lsbp_back #(
    parameter int MAX_STRAND_COUNT = 16,
    parameter int STRAND_BYTES     = 2048
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  lsbp_pkg::cfg_wr_t cfg,
    input  wire               q_valid,
    input  lsbp_pkg::op_t     q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  wire               m_ready,
    output lsbp_pkg::out_t    m_payload
);
    import lsbp_pkg::*;

    localparam int NB     = MAX_STRAND_COUNT - 1;
    localparam int BANK_W = (NB > 1) ? $clog2(NB) : 1;
    localparam int ADDR_W = $clog2(STRAND_BYTES);
    localparam int LEN_W  = $clog2(STRAND_BYTES + 1);
    localparam int POS_W  = $clog2(8 * STRAND_BYTES + 3);
    localparam int TOT_W  = POS_W + 1;

    back_state_t        state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_payload_reg, out_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   pix_reg;
    logic [LEN_W-1:0]   len_reg [NB];
    logic [3:0]         first_reg;
    logic [4:0]         last_reg;

    logic               out_free;
    logic               out_load;
    logic               bank_we;
    logic               len_we;
    logic               rd_en;
    logic [POS_W-1:0]   pos_rel;
    logic [LEN_W-1:0]   pix_next;
    logic [2:0]         plane;
    logic [NB-1:0]      in_range;
    logic [NB-1:0][7:0] bank_rd;
    logic [7:0]         lanes;
    logic [7:0]         frame_byte;
    logic [STRAND_SUM_W-1:0] first_sum;
    logic [LEN_W-1:0]   len0;
    logic [TOT_W-1:0]   total;
    logic               frame_last;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign pos_rel   = pos_reg - POS_W'(3);
    assign pix_next  = LEN_W'(pos_rel >> 3);
    assign plane     = pos_rel[2:0];

    for (genvar b = 0; b < NB; b++) begin : g_bank
        logic [7:0] mem [STRAND_BYTES];
        logic [7:0] rd_q;

        always_ff @(posedge aclk) begin
            if (bank_we && (q_head.strand[BANK_W-1:0] == BANK_W'(b))) begin
                mem[q_head.addr[ADDR_W-1:0]] <= q_head.data;
            end
        end

        always_ff @(posedge aclk) begin
            if (rd_en) begin
                rd_q <= mem[pix_next[ADDR_W-1:0]];
            end
        end

        assign bank_rd[b]  = rd_q;
        assign in_range[b] = pix_reg < len_reg[b];
    end

    always_comb begin
        logic [STRAND_SUM_W-1:0] s_sum;
        logic [BANK_W-1:0]       s_idx;
        lanes = '0;
        for (int k = 0; k < 8; k++) begin
            s_sum = STRAND_SUM_W'(first_reg) + STRAND_SUM_W'(k);
            s_idx = s_sum[BANK_W-1:0];
            if ((s_sum < STRAND_SUM_W'(NB)) && (s_sum < STRAND_SUM_W'(last_reg))) begin
                lanes[k] = in_range[s_idx] && bank_rd[s_idx][~plane];
            end
        end
    end

    assign first_sum = STRAND_SUM_W'(first_reg);
    assign len0      = (first_sum < STRAND_SUM_W'(NB)) ? len_reg[first_sum[BANK_W-1:0]] : '0;
    assign total     = TOT_W'(3) + (TOT_W'(len0) << 3);
    assign frame_last = (TOT_W'(pos_reg) + TOT_W'(1)) >= total;

    always_comb begin
        if (pos_reg == '0) begin
            frame_byte = FRAME_MARK;
        end else if (pos_reg < POS_W'(3)) begin
            frame_byte = '0;
        end else begin
            frame_byte = lanes;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        bank_we    = 1'b0;
        len_we     = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        out_next   = m_payload_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    unique case (q_head.kind) inside
                        OP_WRITE: begin
                            bank_we = 1'b1;
                            q_pop   = 1'b1;
                        end
                        OP_SETLEN: begin
                            len_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        OP_BEGIN, OP_END: begin
                            if (out_free) begin
                                out_load          = 1'b1;
                                q_pop             = 1'b1;
                                out_next.out_kind = (q_head.kind == OP_BEGIN) ?
                                                    KIND_BEGIN : KIND_END;
                                out_next.out_byte = '0;
                                out_next.out_last = 1'b0;
                            end
                        end
                        OP_PULL: begin
                            q_pop      = 1'b1;
                            rd_en      = 1'b1;
                            state_next = BK_GATHER;
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_GATHER: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    out_next.out_kind = KIND_BYTE;
                    out_next.out_byte = frame_byte;
                    out_next.out_last = frame_last;
                    pos_next          = frame_last ? '0 : pos_reg + POS_W'(1);
                    state_next        = BK_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NB; s++) begin
                len_reg[s] <= '0;
            end
        end else if (len_we) begin
            len_reg[q_head.strand[BANK_W-1:0]] <= LEN_W'(q_head.length);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 4'd0;
            last_reg  <= 5'd8;
        end else if (cfg.we) begin
            unique case (cfg.index)
                CFG_FIRST_STRAND: first_reg <= cfg.data[3:0];
                CFG_LAST_STRAND:  last_reg  <= cfg.data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_payload_reg <= out_next;
        end
        if (rd_en) begin
            pix_reg <= pix_next;
        end
    end

    a_pull_gathers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_IDLE && q_valid && q_head.kind == OP_PULL) |=>
        (state_reg == BK_GATHER))
        else $error("Pull transfer did not start a gather.");

    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_next.out_kind == KIND_BYTE && out_next.out_last) |=>
        (pos_reg == '0))
        else $error("Frame position did not return to zero after the last byte.");

    a_gather_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_GATHER && out_free) |=>
        (state_reg == BK_IDLE && m_valid_reg))
        else $error("Gathered byte was not presented on the output.");

endmodule
`default_nettype wire

@@ hw/rtl/led_strand_bitplane_packer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED strand bit-plane packer
// Parses strand packets into banked per-strand stores and emits a frame of
// bit-plane bytes, each built from one pixel byte of up to eight strands.
// ----------------------------------------------------------------------------
// A pull passes through the operation queue, the registered strand store read
// and the output register; begin and end events skip the store read.
// Throughput: packet bytes are taken one per cycle while the queue is not full;
// the execution side takes no new queue entry until a pull's byte is registered.
// Reset: synchronous on aresetn low; lengths, parser and frame position clear,
// strand stores keep their contents and need no clearing pass.
module led_strand_bitplane_packer_core #(
    parameter int MAX_STRAND_COUNT = 16,
    parameter int STRAND_BYTES     = 2048
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire  [lsbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [lsbp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  lsbp_pkg::in_t                      s_payload,
    output logic                               m_valid,
    input  wire                                m_ready,
    output lsbp_pkg::out_t                     m_payload
);
    import lsbp_pkg::*;

    cfg_wr_t cfg;
    logic    q_full;
    logic    q_push;
    op_t     q_entry;
    logic    q_pop;
    logic    q_valid;
    op_t     q_head;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    lsbp_front #(
        .MAX_STRAND_COUNT (MAX_STRAND_COUNT),
        .STRAND_BYTES     (STRAND_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    lsbp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    lsbp_back #(
        .MAX_STRAND_COUNT (MAX_STRAND_COUNT),
        .STRAND_BYTES     (STRAND_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
`default_nettype wire

@@ tb/sv/led_strand_bitplane_packer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strand bit-plane packer core testbench
// Sends strand, begin/end and malformed packets interleaved with frame pulls,
// under random gaps and back-pressure. Each strand window is set while the
// block is idle. Every event and frame byte is compared with a model of the
// packet parser, the strand stores and the bit-plane transpose.
// ----------------------------------------------------------------------------
module led_strand_bitplane_packer_core_tb;
    import lsbp_pkg::*;

    localparam int NSTR = 16;
    localparam int SBYTES = 2048;
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_PULL = 1'b1;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_CAP = 100;

    class packer_scoreboard;
        logic [7:0]  strand_mem [NSTR][SBYTES];
        bit          written [NSTR][SBYTES];
        logic [11:0] strand_len [NSTR];
        logic [16:0] parse_pos;
        logic [7:0]  pkt_cmd;
        logic [7:0]  pkt_strand;
        logic [15:0] pkt_len;
        logic [14:0] frame_pos;
        logic [3:0]  base_strand;
        logic [4:0]  stop_strand;
        out_t        expected_frame_out [$];
        int          errors;

        function new();
            foreach (strand_len[s]) strand_len[s] = '0;
            parse_pos = '0;
            pkt_cmd = '0;
            pkt_strand = '0;
            pkt_len = '0;
            frame_pos = '0;
            base_strand = 4'd0;
            stop_strand = 5'd8;
            errors = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FIRST_STRAND) begin
                base_strand = data[3:0];
            end else begin
                stop_strand = data;
            end
        endfunction

        // Also tells whether the byte touches a stored pixel that was never written.
        function logic [7:0] plane_byte(output bit safe);
            int pix, plane, s;
            logic [7:0] v;
            v = '0;
            safe = 1'b1;
            if (frame_pos < 3) return (frame_pos == 0) ? FRAME_MARK : 8'h00;
            pix = (int'(frame_pos) - 3) >> 3;
            plane = (int'(frame_pos) - 3) & 7;
            for (int k = 0; k < 8; k++) begin
                s = base_strand + k;
                if (s >= stop_strand || s >= NSTR) break;
                if (pix < strand_len[s] && pix < SBYTES) begin
                    if (!written[s][pix]) safe = 1'b0;
                    v[k] = strand_mem[s][pix][7 - plane];
                end
            end
            return v;
        endfunction

        function bit pull_safe();
            bit safe;
            logic [7:0] unused;
            unused = plane_byte(safe);
            return safe;
        endfunction

        function bit strand_clean(input int s);
            for (int a = 0; a < strand_len[s]; a++) begin
                if (!written[s][a]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_input(input in_t item);
            int total, idx, off, addr;
            bit safe;
            out_t r;
            if (item.action == ACT_PULL) begin
                total = 3 + 8 * int'(strand_len[base_strand]);
                r.out_kind = KIND_BYTE;
                r.out_byte = plane_byte(safe);
                if (int'(frame_pos) + 1 >= total) begin
                    r.out_last = 1'b1;
                    frame_pos = '0;
                end else begin
                    r.out_last = 1'b0;
                    frame_pos = frame_pos + 1'b1;
                end
                expected_frame_out.push_back(r);
                return;
            end
            if (item.packet_first) begin
                parse_pos = 17'd1;
                pkt_cmd = item.packet_byte;
                if (pkt_cmd == CMD_BEGIN || pkt_cmd == CMD_END) begin
                    r.out_kind = (pkt_cmd == CMD_BEGIN) ? KIND_BEGIN : KIND_END;
                    r.out_byte = 8'h00;
                    r.out_last = 1'b0;
                    expected_frame_out.push_back(r);
                end
                return;
            end
            if (pkt_cmd == CMD_STRAND) begin
                idx = parse_pos;
                if (idx == 1) begin
                    pkt_strand = item.packet_byte;
                end else if (idx == 2) begin
                    pkt_len[7:0] = item.packet_byte;
                end else if (idx == 3) begin
                    pkt_len[15:8] = item.packet_byte;
                    if (pkt_strand < NSTR - 1) begin
                        strand_len[pkt_strand] = (pkt_len < SBYTES) ? pkt_len[11:0] : 12'(SBYTES);
                    end
                end else if (idx >= 4) begin
                    off = idx - 4;
                    if (pkt_strand < NSTR - 1 && off < pkt_len && off < SBYTES) begin
                        addr = off;
                        if (off % 3 == 0 && off + 1 < pkt_len) begin
                            addr = off + 1;
                        end else if (off % 3 == 1) begin
                            addr = off - 1;
                        end
                        if (addr < SBYTES) begin
                            strand_mem[pkt_strand][addr] = item.packet_byte;
                            written[pkt_strand][addr] = 1'b1;
                        end
                    end
                end
            end
            if (parse_pos != PARSE_MAX) parse_pos = parse_pos + 1'b1;
        endfunction

        function void report(input string field, input int want, input int got);
            errors++;
            if (errors <= REPORT_CAP) $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(input out_t got);
            out_t want;
            if (expected_frame_out.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $error("result with nothing pending: kind %0d byte %0d last %0d",
                           got.out_kind, got.out_byte, got.out_last);
                end
                return;
            end
            want = expected_frame_out.pop_front();
            if (got.out_kind !== want.out_kind) report("out_kind", want.out_kind, got.out_kind);
            if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
            if (got.out_last !== want.out_last) report("out_last", want.out_last, got.out_last);
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    packer_scoreboard board;
    in_t packet_stream [$];
    bit calm = 1'b0;
    bit hold_off_req = 1'b0;
    int tx_run_left = 0;
    bit tx_run_quiet = 1'b0;
    int quiet_cycles = 0;

    led_strand_bitplane_packer_core #(
        .MAX_STRAND_COUNT(NSTR),
        .STRAND_BYTES(SBYTES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        int stall_left;
        int window_left;
        bit window_quiet;
        bit held;
        stall_left = 0;
        window_left = 0;
        window_quiet = 1'b0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) board.check_result(m_payload);
            if (hold_off_req && !held) begin
                held = 1'b1;
                stall_left = 300;
            end
            if (window_left == 0) begin
                window_left = $urandom_range(20, 80);
                window_quiet = ($urandom_range(0, 2) == 0);
            end
            window_left--;
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!calm && !window_quiet && $urandom_range(0, 99) < 20) begin
                    stall_left = $urandom_range(1, 4);
                end
            end
        end
    end

    function automatic in_t byte_item(input logic [7:0] v, input logic first_flag);
        in_t item;
        item.action = ACT_BYTE;
        item.packet_byte = v;
        item.packet_first = first_flag;
        return item;
    endfunction

    function automatic in_t pull_item();
        in_t item;
        item.action = ACT_PULL;
        item.packet_byte = 8'($urandom);
        item.packet_first = 1'($urandom);
        return item;
    endfunction

    // A cut of n keeps only the first n bytes; extra adds bytes past the payload.
    function automatic void queue_strand_packet(input logic [7:0] strand, input int len,
                                                input int cut, input int extra);
        in_t pkt [$];
        pkt.push_back(byte_item(CMD_STRAND, 1'b1));
        pkt.push_back(byte_item(strand, 1'b0));
        pkt.push_back(byte_item(len[7:0], 1'b0));
        pkt.push_back(byte_item(len[15:8], 1'b0));
        for (int i = 0; i < len && (cut < 0 || i + 4 < cut); i++) begin
            pkt.push_back(byte_item(8'($urandom), 1'b0));
        end
        foreach (pkt[i]) begin
            if (cut < 0 || i < cut) packet_stream.push_back(pkt[i]);
        end
        repeat (extra) packet_stream.push_back(byte_item(8'($urandom), 1'b0));
    endfunction

    function automatic void queue_random_packet();
        int pick, len, strand;
        logic [7:0] cmd;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 59) == 0) begin
            len = $urandom_range(256, 300);
        end else if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(25, 60);
        end else begin
            len = $urandom_range(0, 24);
        end
        strand = $urandom_range(0, NSTR - 2);
        for (int s = 0; s < NSTR - 1; s++) begin
            if (!board.strand_clean(s)) strand = s;
        end
        if (pick < 12) begin
            packet_stream.push_back(byte_item(CMD_BEGIN, 1'b1));
        end else if (pick < 24) begin
            packet_stream.push_back(byte_item(CMD_END, 1'b1));
        end else if (pick < 30) begin
            do cmd = 8'($urandom);
            while (cmd == CMD_BEGIN || cmd == CMD_END || cmd == CMD_STRAND);
            packet_stream.push_back(byte_item(cmd, 1'b1));
            repeat ($urandom_range(0, 3)) packet_stream.push_back(byte_item(8'($urandom), 1'b0));
        end else if (pick < 38) begin
            len = $urandom_range(1, 20);
            queue_strand_packet(8'($urandom_range(0, NSTR - 2)), len,
                                $urandom_range(1, 3 + len), 0);
        end else if (pick < 44) begin
            queue_strand_packet(8'($urandom_range(NSTR - 1, 255)), $urandom_range(0, 8), -1, 0);
        end else if (pick < 50) begin
            queue_strand_packet(8'(strand), len, -1, $urandom_range(1, 3));
        end else begin
            queue_strand_packet(8'(strand), len, -1, 0);
        end
    endfunction

    task automatic send_item(input in_t item);
        s_valid <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(item);
        if (tx_run_left == 0) begin
            tx_run_left = $urandom_range(10, 60);
            tx_run_quiet = ($urandom_range(0, 2) == 0);
        end
        tx_run_left--;
        if (!calm && !tx_run_quiet && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic send_stream();
        while (packet_stream.size() > 0) send_item(packet_stream.pop_front());
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (board.expected_frame_out.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_strand_window(input logic [3:0] lo_strand, input logic [4:0] end_strand);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FIRST_STRAND;
        cfg_wdata <= {1'b0, lo_strand};
        @(posedge aclk);
        board.write_reg(CFG_FIRST_STRAND, {1'b0, lo_strand});
        cfg_index <= CFG_LAST_STRAND;
        cfg_wdata <= end_strand;
        @(posedge aclk);
        board.write_reg(CFG_LAST_STRAND, end_strand);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            if (packet_stream.size() == 0) queue_random_packet();
            if ($urandom_range(0, 99) < 35 && board.pull_safe()) begin
                send_item(pull_item());
            end else begin
                send_item(packet_stream.pop_front());
            end
        end
    endtask

    initial begin : stimulus
        int win_lo [6];
        int win_hi [6];
        board = new();
        win_lo = '{0, 15, 5, 0, 9, 3};
        win_hi = '{8, 16, 0, 16, 13, 11};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_strand_window(4'd0, 5'd8);

        repeat (3) send_item(pull_item());
        send_item(byte_item(CMD_BEGIN, 1'b1));
        send_item(byte_item(CMD_END, 1'b1));
        send_item(byte_item(8'h00, 1'b1));
        send_item(byte_item(8'hFF, 1'b0));
        queue_strand_packet(8'(NSTR - 1), 16'hFFFF, 5, 0);
        send_stream();
        send_item(byte_item(CMD_STRAND, 1'b1));
        send_item(byte_item(8'h00, 1'b0));
        send_item(byte_item(8'h04, 1'b0));
        send_item(byte_item(8'h00, 1'b0));
        send_item(byte_item(8'h81, 1'b0));
        send_item(byte_item(8'h7E, 1'b0));
        send_item(byte_item(8'hFF, 1'b0));
        send_item(byte_item(8'h00, 1'b0));
        send_item(byte_item(8'hAA, 1'b0));
        repeat (4) send_item(pull_item());

        // An oversized strand header: the length saturates and only the first pixels follow.
        queue_strand_packet(8'd2, 2050, 12, 0);
        send_stream();
        settle();
        set_strand_window(4'd2, 5'd16);
        do send_item(pull_item());
        while (board.frame_pos != 0 && board.pull_safe());

        for (int p = 0; p < 6; p++) begin
            settle();
            set_strand_window(4'(win_lo[p]), 5'(win_hi[p]));
            if (p == 0) hold_off_req = 1'b1;
            if (p == 5) calm = 1'b1;
            run_random_phase(220);
        end
        settle();
        repeat (16) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/lsbp_pkg.sv
hw/rtl/lsbp_front.sv
hw/rtl/lsbp_fifo.sv
hw/rtl/lsbp_back.sv
hw/rtl/led_strand_bitplane_packer_core.sv
tb/sv/led_strand_bitplane_packer_core_tb.sv
